### rtl/core/mrwt_pkg.sv
// Package with the shared default word width and the sequencer state type of the Miller-Rabin witness test.
package mrwt_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACTOR,
    S_RED,
    S_POW,
    S_PMUL,
    S_PSQ,
    S_TEST,
    S_LOOP,
    S_LSQ,
    S_DONE
  } state_e;

endpackage

### rtl/core/miller_rabin_witness_test_core.sv
// Top level of the Miller-Rabin witness test: sequencer, exponent registers and result register.
// A request strips the k trailing zeros of candidate-1, reduces the witness modulo the candidate,
// raises it to the remaining odd part and then squares the result up to k times.
// All modular products share one bit-serial multiplier that handles one bit per cycle.
// A request is taken only while the sequencer is idle; one result register decouples output.
// Reset clears the sequencer and the result valid flag; payload registers are not reset.
module miller_rabin_witness_test_core #(
  parameter int unsigned WORD_BITS = mrwt_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] candidate_i,
  input  logic [WORD_BITS-1:0] witness_base_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 probably_prime_o,
  output logic                 bad_input_o
);

  localparam int unsigned KW = $clog2(WORD_BITS + 1);

  mrwt_pkg::state_e state_q, state_d;

  logic [WORD_BITS-1:0] n_q, n_d, nm1_q, nm1_d, a_q, a_d;
  logic [WORD_BITS-1:0] e_q, e_d, base_q, base_d, acc_q, acc_d;
  logic [KW-1:0]        k_q, k_d, j_q, j_d;
  logic                 pass_q, pass_d, bad_q, bad_d;
  logic                 ov_q, ov_d, op_q, op_d, ob_q, ob_d;

  logic                 mul_start, mul_busy, mul_done;
  logic [WORD_BITS-1:0] mul_x, mul_y, mul_res;
  logic                 accept;

  mrwt_modmul #(.WORD_BITS(WORD_BITS)) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .n_i    (n_q),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrwt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (candidate_i[WORD_BITS-1:1] == '0) ? mrwt_pkg::S_DONE
                                                         : mrwt_pkg::S_FACTOR;
        end
      end
      mrwt_pkg::S_FACTOR: begin
        if (e_q[0] || k_q == KW'(WORD_BITS)) state_d = mrwt_pkg::S_RED;
      end
      mrwt_pkg::S_RED: begin
        if (mul_done) state_d = mrwt_pkg::S_POW;
      end
      mrwt_pkg::S_POW: begin
        if (e_q == '0)   state_d = mrwt_pkg::S_TEST;
        else if (e_q[0]) state_d = mrwt_pkg::S_PMUL;
        else             state_d = mrwt_pkg::S_PSQ;
      end
      mrwt_pkg::S_PMUL: begin
        if (mul_done) state_d = mrwt_pkg::S_PSQ;
      end
      mrwt_pkg::S_PSQ: begin
        if (mul_done) state_d = mrwt_pkg::S_POW;
      end
      mrwt_pkg::S_TEST: begin
        if (acc_q == WORD_BITS'(1) || acc_q == nm1_q) state_d = mrwt_pkg::S_DONE;
        else                                          state_d = mrwt_pkg::S_LOOP;
      end
      mrwt_pkg::S_LOOP: begin
        state_d = (j_q < k_q) ? mrwt_pkg::S_LSQ : mrwt_pkg::S_DONE;
      end
      mrwt_pkg::S_LSQ: begin
        if (mul_done) begin
          if (mul_res == WORD_BITS'(1) || mul_res == nm1_q) state_d = mrwt_pkg::S_DONE;
          else                                             state_d = mrwt_pkg::S_LOOP;
        end
      end
      mrwt_pkg::S_DONE: begin
        if (!ov_q || out_ready_i) state_d = mrwt_pkg::S_IDLE;
      end
      default: state_d = mrwt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mul_start  = 1'b0;
    mul_x      = acc_q;
    mul_y      = base_q;
    n_d        = n_q;
    nm1_d      = nm1_q;
    a_d        = a_q;
    e_d        = e_q;
    base_d     = base_q;
    acc_d      = acc_q;
    k_d        = k_q;
    j_d        = j_q;
    pass_d     = pass_q;
    bad_d      = bad_q;
    ov_d       = ov_q && !out_ready_i;
    op_d       = op_q;
    ob_d       = ob_q;
    unique case (state_q)
      mrwt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        n_d        = candidate_i;
        nm1_d      = candidate_i - WORD_BITS'(1);
        e_d        = candidate_i - WORD_BITS'(1);
        a_d        = witness_base_i;
        k_d        = '0;
        j_d        = '0;
        pass_d     = 1'b0;
        bad_d      = (candidate_i[WORD_BITS-1:1] == '0);
      end
      mrwt_pkg::S_FACTOR: begin
        if (e_q[0] || k_q == KW'(WORD_BITS)) begin
          mul_start = 1'b1;
          mul_x     = WORD_BITS'(1);
          mul_y     = a_q;
        end else begin
          e_d = {1'b0, e_q[WORD_BITS-1:1]};
          k_d = k_q + KW'(1);
        end
      end
      mrwt_pkg::S_RED: begin
        if (mul_done) begin
          base_d = mul_res;
          acc_d  = WORD_BITS'(1);
        end
      end
      mrwt_pkg::S_POW: begin
        if (e_q != '0) begin
          mul_start = 1'b1;
          if (!e_q[0]) mul_x = base_q;
        end
      end
      mrwt_pkg::S_PMUL: begin
        if (mul_done) begin
          acc_d     = mul_res;
          mul_start = 1'b1;
          mul_x     = base_q;
        end
      end
      mrwt_pkg::S_PSQ: begin
        if (mul_done) begin
          base_d = mul_res;
          e_d    = {1'b0, e_q[WORD_BITS-1:1]};
        end
      end
      mrwt_pkg::S_TEST: begin
        if (acc_q == WORD_BITS'(1) || acc_q == nm1_q) pass_d = 1'b1;
      end
      mrwt_pkg::S_LOOP: begin
        if (j_q < k_q) begin
          mul_start = 1'b1;
          mul_y     = acc_q;
        end
      end
      mrwt_pkg::S_LSQ: begin
        if (mul_done) begin
          acc_d = mul_res;
          j_d   = j_q + KW'(1);
          if (mul_res != WORD_BITS'(1) && mul_res == nm1_q) pass_d = 1'b1;
        end
      end
      mrwt_pkg::S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          op_d = pass_q && !bad_q;
          ob_d = bad_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrwt_pkg::S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    nm1_q  <= nm1_d;
    a_q    <= a_d;
    e_q    <= e_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    k_q    <= k_d;
    j_q    <= j_d;
    pass_q <= pass_d;
    bad_q  <= bad_d;
    op_q   <= op_d;
    ob_q   <= ob_d;
  end

  assign out_valid_o      = ov_q;
  assign probably_prime_o = op_q;
  assign bad_input_o      = ob_q;

  a_excl_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(probably_prime_o && bad_input_o))
    else $error("Result flags both set.");

  a_bad_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && candidate_i[WORD_BITS-1:1] == '0) |=> state_q == mrwt_pkg::S_DONE)
    else $error("Small candidate did not go straight to the result.");

  a_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mrwt_pkg::S_IDLE |-> !mul_busy)
    else $error("Multiplier busy while idle.");

  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("Multiplier started while busy.");

endmodule

### rtl/core/mrwt_modmul.sv
// Bit-serial modular multiplier that handles one multiplier bit per cycle by double-and-add.
module mrwt_modmul #(
  parameter int unsigned WORD_BITS = mrwt_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] x_i,
  input  logic [WORD_BITS-1:0] y_i,
  input  logic [WORD_BITS-1:0] n_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] res_o
);

  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WORD_BITS-1:0] x_q, x_d;
  logic [WORD_BITS-1:0] y_q, y_d;
  logic [WORD_BITS-1:0] n_q, n_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [WORD_BITS:0]   dbl, dbl_red, sum, sum_red;

  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    sum     = dbl_red + {1'b0, x_q};
    sum_red = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    n_d    = n_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WORD_BITS);
      x_d    = x_i;
      y_d    = y_i;
      n_d    = n_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = y_q[WORD_BITS-1] ? sum_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
      y_d   = {y_q[WORD_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    n_q   <= n_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule
